// ----- hw/rtl/crm_pkg.sv -----
package crm_pkg;

    // Default geometry of the layer.
    localparam int IMAGE_SIZE_DEF = 28;
    localparam int FILTERS_DEF    = 8;

    // Fixed field widths.
    localparam int IDX_W   = 7;
    localparam int COEF_W  = 32;
    localparam int PIX_W   = 16;
    localparam int POS_OUT_W = 4;
    localparam int CHAN_W  = 35;
    localparam int SUM_W   = 36;
    localparam int PROD_W  = 32;
    localparam int OUT_CHANS = 8;
    localparam int TAPS    = 9;

    // Command codes of an input transaction.
    localparam logic CMD_COEF  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Class of a queued item after decoding.
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_WEIGHT,
        KIND_BIAS,
        KIND_PIXEL
    } kind_t;

    typedef struct packed {
        logic                     command;
        logic [IDX_W-1:0]         coef_index;
        logic signed [COEF_W-1:0] coef_value;
        logic signed [PIX_W-1:0]  pixel;
    } in_item_t;

    typedef struct packed {
        logic [POS_OUT_W-1:0] pool_row;
        logic [POS_OUT_W-1:0] pool_col;
        logic [CHAN_W-1:0]    chan0;
        logic [CHAN_W-1:0]    chan1;
        logic [CHAN_W-1:0]    chan2;
        logic [CHAN_W-1:0]    chan3;
        logic [CHAN_W-1:0]    chan4;
        logic [CHAN_W-1:0]    chan5;
        logic [CHAN_W-1:0]    chan6;
        logic [CHAN_W-1:0]    chan7;
        logic                 frame_end;
    } out_item_t;

    // Decoded item as it travels from the front part to the back part.
    typedef struct packed {
        kind_t                    kind;
        logic [IDX_W-1:0]         idx;
        logic signed [COEF_W-1:0] value;
        logic signed [PIX_W-1:0]  pixel;
    } entry_t;

endpackage

// ----- hw/rtl/crm_front.sv -----
module crm_front #(
    parameter int FILTERS = crm_pkg::FILTERS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  crm_pkg::in_item_t in_data,
    output logic              q_valid,
    input  logic              q_pop,
    output crm_pkg::entry_t   q_entry
);

    localparam int NUM_W = FILTERS * crm_pkg::TAPS;
    localparam int DEPTH = 2;

    crm_pkg::entry_t q_mem [DEPTH];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    crm_pkg::entry_t dec;
    logic            push;

    // Decode the incoming transaction and saturate weights to 16 bits.
    always_comb
    begin
        dec.idx   = in_data.coef_index;
        dec.pixel = in_data.pixel;
        dec.value = in_data.coef_value;
        if (in_data.command == crm_pkg::CMD_PIXEL)
        begin
            dec.kind = crm_pkg::KIND_PIXEL;
        end
        else if (int'(in_data.coef_index) < NUM_W)
        begin
            dec.kind = crm_pkg::KIND_WEIGHT;
            if (in_data.coef_value > 32'sd32767)
            begin
                dec.value = 32'sd32767;
            end
            else if (in_data.coef_value < -32'sd32768)
            begin
                dec.value = -32'sd32768;
            end
        end
        else if (int'(in_data.coef_index) < NUM_W + FILTERS)
        begin
            dec.kind = crm_pkg::KIND_BIAS;
        end
        else
        begin
            dec.kind = crm_pkg::KIND_NONE;
        end
    end

    assign in_stall = (count_reg == 2'(DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_entry  = q_mem[rd_ptr_reg];

    // Queue pointers and fill level.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= dec;
        end
    end

endmodule

// ----- hw/rtl/crm_back.sv -----
module crm_back #(
    parameter int IMAGE_SIZE = crm_pkg::IMAGE_SIZE_DEF,
    parameter int FILTERS    = crm_pkg::FILTERS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_pop,
    input  crm_pkg::entry_t    q_entry,
    output logic               dst_valid,
    input  logic               dst_stall,
    output crm_pkg::out_item_t dst_data
);

    localparam int NUM_W   = FILTERS * crm_pkg::TAPS;
    localparam int POOL    = (IMAGE_SIZE - 2) / 2;
    localparam int LA_W    = $clog2(IMAGE_SIZE);
    localparam int POS_W   = (LA_W < crm_pkg::POS_OUT_W) ? crm_pkg::POS_OUT_W : LA_W;
    localparam int PC_W    = (POOL > 1) ? $clog2(POOL) : 1;
    localparam int CW      = crm_pkg::CHAN_W;
    localparam int SW      = crm_pkg::SUM_W;
    localparam int PW      = crm_pkg::PIX_W;

    typedef struct packed {
        logic             conv_ok;
        logic             iodd;
        logic             jodd;
        logic             last;
        logic [POS_W-1:0] prow;
        logic [POS_W-1:0] pc;
        logic [POS_W-1:0] col;
    } meta_t;

    logic               adv;
    logic [POS_W-1:0]   row_reg;
    logic [POS_W-1:0]   row_next;
    logic [POS_W-1:0]   col_reg;
    logic [POS_W-1:0]   col_next;
    meta_t              pop_meta;
    logic [POS_W-1:0]   ri;
    logic [POS_W-1:0]   cj;

    logic [2*PW-1:0]    line_mem [IMAGE_SIZE];
    logic [2*PW-1:0]    line_rd_reg;

    logic signed [PW-1:0]     win_reg [crm_pkg::TAPS];
    logic signed [PW-1:0]     w_reg [NUM_W];
    logic signed [31:0]       b_reg [FILTERS];

    logic               s1_v_reg;
    crm_pkg::entry_t    s1_e_reg;
    meta_t              s1_m_reg;
    logic               s2_v_reg;
    meta_t              s2_m_reg;
    logic               s3_v_reg;
    meta_t              s3_m_reg;
    logic               s4_v_reg;
    meta_t              s4_m_reg;
    logic               s5_v_reg;
    meta_t              s5_m_reg;

    logic signed [crm_pkg::PROD_W-1:0] prod_reg [FILTERS][crm_pkg::TAPS];
    logic signed [31:0]                bias_q_reg [FILTERS];
    logic signed [SW-1:0]              psum_reg [FILTERS][3];
    logic [CW-1:0]                     val_reg [FILTERS];
    logic [CW-1:0]                     colp_reg [FILTERS];
    logic [FILTERS*CW-1:0]             rowp_mem [POOL];
    logic [FILTERS*CW-1:0]             rowp_rd_reg;
    logic [FILTERS*CW-1:0]             rowp_wr;
    logic [CW-1:0]                     pool_max [FILTERS];
    logic [CW-1:0]                     res [crm_pkg::OUT_CHANS];

    logic               dst_valid_reg;
    logic               dst_valid_next;
    crm_pkg::out_item_t dst_data_reg;
    crm_pkg::out_item_t dst_data_next;

    function automatic logic [CW-1:0] relu(input logic signed [SW-1:0] s);
        relu = s[SW-1] ? '0 : s[CW-1:0];
    endfunction

    // The whole back pipeline moves when the output register can take a result.
    assign adv   = !dst_valid_reg || !dst_stall;
    assign q_pop = adv && q_valid;

    // Classify the pixel position for convolution and pooling.
    always_comb
    begin
        ri = row_reg - POS_W'(2);
        cj = col_reg - POS_W'(2);
        pop_meta.conv_ok = (row_reg >= POS_W'(2)) && (col_reg >= POS_W'(2))
                        && (ri < POS_W'(2 * POOL)) && (cj < POS_W'(2 * POOL));
        pop_meta.iodd = ri[0];
        pop_meta.jodd = cj[0];
        pop_meta.prow = ri >> 1;
        pop_meta.pc   = cj >> 1;
        pop_meta.last = ((ri >> 1) == POS_W'(POOL - 1)) && ((cj >> 1) == POS_W'(POOL - 1));
        pop_meta.col  = col_reg;
        col_next = col_reg;
        row_next = row_reg;
        if (q_pop && q_entry.kind == crm_pkg::KIND_PIXEL)
        begin
            if (col_reg == POS_W'(IMAGE_SIZE - 1))
            begin
                col_next = '0;
                row_next = (row_reg == POS_W'(IMAGE_SIZE - 1)) ? '0 : row_reg + POS_W'(1);
            end
            else
            begin
                col_next = col_reg + POS_W'(1);
            end
        end
    end

    // Pipeline control and position counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            s4_v_reg      <= 1'b0;
            s5_v_reg      <= 1'b0;
            dst_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            s1_v_reg      <= q_valid;
            s2_v_reg      <= s1_v_reg && s1_e_reg.kind == crm_pkg::KIND_PIXEL;
            s3_v_reg      <= s2_v_reg;
            s4_v_reg      <= s3_v_reg;
            s5_v_reg      <= s4_v_reg;
            dst_valid_reg <= dst_valid_next;
        end
    end

    // Stage one: line buffer read, queue item capture.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_e_reg    <= q_entry;
            s1_m_reg    <= pop_meta;
            line_rd_reg <= line_mem[col_reg[LA_W-1:0]];
        end
    end

    // Line buffer update and coefficient writes happen as the item leaves stage one.
    always_ff @(posedge clk)
    begin
        if (adv && s1_v_reg)
        begin
            if (s1_e_reg.kind == crm_pkg::KIND_PIXEL)
            begin
                line_mem[s1_m_reg.col[LA_W-1:0]] <= {s1_e_reg.pixel, line_rd_reg[2*PW-1:PW]};
            end
            for (int k = 0; k < NUM_W; k++)
            begin
                if (s1_e_reg.kind == crm_pkg::KIND_WEIGHT && int'(s1_e_reg.idx) == k)
                begin
                    w_reg[k] <= s1_e_reg.value[PW-1:0];
                end
            end
            for (int f = 0; f < FILTERS; f++)
            begin
                if (s1_e_reg.kind == crm_pkg::KIND_BIAS && int'(s1_e_reg.idx) == NUM_W + f)
                begin
                    b_reg[f] <= s1_e_reg.value;
                end
            end
        end
    end

    // 3x3 window shifts in one column per pixel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < crm_pkg::TAPS; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (adv && s1_v_reg && s1_e_reg.kind == crm_pkg::KIND_PIXEL)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k*3]   <= win_reg[k*3+1];
                win_reg[k*3+1] <= win_reg[k*3+2];
            end
            win_reg[2] <= line_rd_reg[PW-1:0];
            win_reg[5] <= line_rd_reg[2*PW-1:PW];
            win_reg[8] <= s1_e_reg.pixel;
        end
    end

    // Multiply, partial sums, total with ReLU.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_m_reg <= s1_m_reg;
            s3_m_reg <= s2_m_reg;
            s4_m_reg <= s3_m_reg;
            s5_m_reg <= s4_m_reg;
            for (int f = 0; f < FILTERS; f++)
            begin
                for (int t = 0; t < crm_pkg::TAPS; t++)
                begin
                    prod_reg[f][t] <= win_reg[t] * w_reg[f*crm_pkg::TAPS+t];
                end
                bias_q_reg[f] <= b_reg[f];
                psum_reg[f][0] <= SW'(prod_reg[f][0]) + SW'(prod_reg[f][1])
                                + SW'(prod_reg[f][2]);
                psum_reg[f][1] <= SW'(prod_reg[f][3]) + SW'(prod_reg[f][4])
                                + SW'(prod_reg[f][5]);
                psum_reg[f][2] <= SW'(prod_reg[f][6]) + SW'(prod_reg[f][7])
                                + SW'(prod_reg[f][8]) + SW'(bias_q_reg[f]);
                val_reg[f] <= relu(psum_reg[f][0] + psum_reg[f][1] + psum_reg[f][2]);
            end
            rowp_rd_reg <= rowp_mem[s4_m_reg.pc[PC_W-1:0]];
        end
    end

    // Pooling: horizontal pair, then the upper row pair against the lower one.
    always_comb
    begin
        for (int f = 0; f < FILTERS; f++)
        begin
            rowp_wr[f*CW +: CW] = (colp_reg[f] > val_reg[f]) ? colp_reg[f] : val_reg[f];
            pool_max[f] = (rowp_rd_reg[f*CW +: CW] > rowp_wr[f*CW +: CW])
                        ? rowp_rd_reg[f*CW +: CW] : rowp_wr[f*CW +: CW];
        end
        for (int k = 0; k < crm_pkg::OUT_CHANS; k++)
        begin
            res[k] = '0;
            if (k < FILTERS)
            begin
                res[k] = pool_max[k];
            end
        end
        dst_valid_next          = s5_v_reg && s5_m_reg.conv_ok && s5_m_reg.iodd && s5_m_reg.jodd;
        dst_data_next.pool_row  = s5_m_reg.prow[crm_pkg::POS_OUT_W-1:0];
        dst_data_next.pool_col  = s5_m_reg.pc[crm_pkg::POS_OUT_W-1:0];
        dst_data_next.chan0     = res[0];
        dst_data_next.chan1     = res[1];
        dst_data_next.chan2     = res[2];
        dst_data_next.chan3     = res[3];
        dst_data_next.chan4     = res[4];
        dst_data_next.chan5     = res[5];
        dst_data_next.chan6     = res[6];
        dst_data_next.chan7     = res[7];
        dst_data_next.frame_end = s5_m_reg.last;
    end

    // Pool partial storage and output register.
    always_ff @(posedge clk)
    begin
        if (adv && s5_v_reg && s5_m_reg.conv_ok)
        begin
            if (!s5_m_reg.jodd)
            begin
                colp_reg <= val_reg;
            end
            else if (!s5_m_reg.iodd)
            begin
                rowp_mem[s5_m_reg.pc[PC_W-1:0]] <= rowp_wr;
            end
        end
        if (adv)
        begin
            dst_data_reg <= dst_data_next;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst_data  = dst_data_reg;

endmodule

// ----- hw/rtl/conv3x3_relu_maxpool_layer.sv -----
// Streaming first CNN layer: 3x3 convolution over FILTERS filters, bias, ReLU
// and 2x2 stride-2 max pooling on a square IMAGE_SIZE x IMAGE_SIZE image.
// Input channel (in_valid/in_stall/in_data): a transaction with command set to
// coefficient loads a weight (filter*9+row*3+col) or a bias; one with command
// set to pixel carries the next image sample in raster order.
// Output channel (dst_valid/dst_stall/dst_data): one transaction per complete
// pool position with all channel values; frame_end marks the last position.
// Throughput is one input transaction per cycle while the receiver does not
// stall, set by the parallel multiply array that handles every filter tap of a
// pixel in the same cycle. An accepted pixel passes the queue, line buffer
// read, window, multiply and two adder stages, and pooling feeds the output
// register. Reset clears the pixel position, window and all valid state;
// coefficients must be loaded before the first frame. When the receiver stalls
// a waiting result the whole back pipeline holds, the two-entry input queue
// fills, and in_stall rises.
module conv3x3_relu_maxpool_layer #(
    parameter int IMAGE_SIZE = crm_pkg::IMAGE_SIZE_DEF,
    parameter int FILTERS    = crm_pkg::FILTERS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  crm_pkg::in_item_t  in_data,
    output logic               dst_valid,
    input  logic               dst_stall,
    output crm_pkg::out_item_t dst_data
);

    logic            q_valid;
    logic            q_pop;
    crm_pkg::entry_t q_entry;

    // Front part: decode and queue.
    crm_front #(
        .FILTERS (FILTERS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_entry  (q_entry)
    );

    // Back part: line buffer, multiply array and pooling.
    crm_back #(
        .IMAGE_SIZE (IMAGE_SIZE),
        .FILTERS    (FILTERS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_entry   (q_entry),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

endmodule

// ----- hw/rtl/crm_checker.sv -----
module crm_checker #(
    parameter int IMAGE_SIZE = crm_pkg::IMAGE_SIZE_DEF
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               dst_valid,
    input logic               dst_stall,
    input crm_pkg::out_item_t dst_data
);

    localparam int POOL = (IMAGE_SIZE - 2) / 2;

    // A stalled result transaction holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_stall |=> dst_valid && $stable(dst_data))
        else $error("stalled result changed");

    // The input queue drains one entry as soon as the receiver is free.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && !dst_stall |=> !in_stall)
        else $error("input stalled while output free");

    // The last position of a frame is the bottom right corner.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_data.frame_end |->
            dst_data.pool_col == crm_pkg::POS_OUT_W'(POOL - 1)
            && dst_data.pool_row == crm_pkg::POS_OUT_W'(POOL - 1))
        else $error("frame end at wrong position");

    // Positions never leave the pooled grid.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && POOL < 16 |->
            dst_data.pool_col < crm_pkg::POS_OUT_W'(POOL)
            && dst_data.pool_row < crm_pkg::POS_OUT_W'(POOL))
        else $error("pool position out of range");

endmodule

bind conv3x3_relu_maxpool_layer crm_checker #(
    .IMAGE_SIZE (IMAGE_SIZE)
) u_crm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
);

// ----- bench/conv3x3_relu_maxpool_layer_tb.sv -----
module conv3x3_relu_maxpool_layer_tb;

    localparam int IMG       = crm_pkg::IMAGE_SIZE_DEF;
    localparam int NFILT     = crm_pkg::FILTERS_DEF;
    localparam int NWEIGHTS  = NFILT * crm_pkg::TAPS;
    localparam int POOL_N    = (IMG - 2) / 2;
    localparam int RANDOM_N  = 1700;
    localparam int HOLD_LEN  = 300;
    localparam int STALL_MAX = 3000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    crm_pkg::in_item_t   in_data;
    logic                dst_valid;
    logic                dst_stall;
    crm_pkg::out_item_t  dst_data;

    conv3x3_relu_maxpool_layer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

    // Shadow copy of the layer state.
    logic [crm_pkg::PIX_W-1:0]  line_mem [2][IMG];
    logic [crm_pkg::PIX_W-1:0]  win [3][3];
    logic [crm_pkg::PIX_W-1:0]  weight_mem [NWEIGHTS];
    logic [crm_pkg::COEF_W-1:0] bias_mem [NFILT];
    logic [crm_pkg::CHAN_W-1:0] row_max [NFILT][POOL_N + 1];
    logic [crm_pkg::CHAN_W-1:0] col_left [NFILT];
    int                         cur_row;
    int                         cur_col;

    crm_pkg::out_item_t pooled_q [$];
    int                 errors = 0;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    bit                 hold_req;
    int                 idle_cycles;

    // Directed stimulus table.
    typedef struct {
        logic        cmd;
        int          idx;
        logic [31:0] value;
        logic [15:0] pix;
        bit          quiet;
    } vec_t;

    vec_t vecs [] = '{
        '{crm_pkg::CMD_COEF,  0,  32'h7FFF_FFFF, 16'h0000, 1},
        '{crm_pkg::CMD_COEF,  1,  32'h8000_0000, 16'h0000, 1},
        '{crm_pkg::CMD_COEF,  2,  32'hFFFF_8000, 16'h0000, 1},
        '{crm_pkg::CMD_COEF,  3,  32'h0000_7FFF, 16'h0000, 1},
        '{crm_pkg::CMD_COEF,  4,  32'h0000_8000, 16'h0000, 1},
        '{crm_pkg::CMD_COEF,  72, 32'h7FFF_FFFF, 16'h0000, 1},
        '{crm_pkg::CMD_COEF,  79, 32'h8000_0000, 16'h0000, 1},
        '{crm_pkg::CMD_COEF,  80, 32'h1234_5678, 16'h0000, 1},
        '{crm_pkg::CMD_COEF,  127, 32'hFFFF_FFFF, 16'h0000, 1},
        '{crm_pkg::CMD_PIXEL, 0,  32'h0,        16'h7FFF, 1},
        '{crm_pkg::CMD_PIXEL, 0,  32'h0,        16'h8000, 1},
        '{crm_pkg::CMD_PIXEL, 0,  32'h0,        16'h0000, 1},
        '{crm_pkg::CMD_PIXEL, 0,  32'h0,        16'hFFFF, 1},
        '{crm_pkg::CMD_PIXEL, 127, 32'hFFFF_FFFF, 16'h7FFF, 1},
        '{crm_pkg::CMD_PIXEL, 0,  32'h0,        16'h1000, 1},
        '{crm_pkg::CMD_COEF,  5,  32'hFFFF_F000, 16'hFFFF, 1},
        '{crm_pkg::CMD_PIXEL, 0,  32'h0,        16'hF000, 1},
        '{crm_pkg::CMD_PIXEL, 0,  32'h0,        16'h8000, 1},
        '{crm_pkg::CMD_PIXEL, 0,  32'h0,        16'h7FFF, 1}
    };

    function automatic logic [crm_pkg::CHAN_W-1:0] filter_relu(int f);
        longint acc;
        acc = longint'($signed(bias_mem[f]));
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                acc += longint'($signed(win[r][c]))
                     * longint'($signed(weight_mem[f*crm_pkg::TAPS + r*3 + c]));
        return (acc < 0) ? '0 : acc[crm_pkg::CHAN_W-1:0];
    endfunction

    // Advance the shadow state by one transaction; returns 1 with a pooled result.
    function automatic bit pool_step(crm_pkg::in_item_t it, output crm_pkg::out_item_t res);
        longint                      w;
        int                          i;
        int                          j;
        int                          pc;
        logic [crm_pkg::CHAN_W-1:0]  v;
        logic [crm_pkg::CHAN_W-1:0]  chans [crm_pkg::OUT_CHANS];
        bit                          emit;
        emit = 0;
        res = '0;
        if (it.command == crm_pkg::CMD_COEF)
        begin
            if (it.coef_index < NWEIGHTS)
            begin
                w = longint'(it.coef_value);
                if (w > 32767) w = 32767;
                if (w < -32768) w = -32768;
                weight_mem[it.coef_index] = w[15:0];
            end
            else if (it.coef_index < NWEIGHTS + NFILT)
            begin
                bias_mem[it.coef_index - NWEIGHTS] = it.coef_value;
            end
            return 0;
        end
        for (int k = 0; k < 3; k++)
        begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = line_mem[0][cur_col];
        win[1][2] = line_mem[1][cur_col];
        win[2][2] = it.pixel;
        line_mem[0][cur_col] = line_mem[1][cur_col];
        line_mem[1][cur_col] = it.pixel;
        for (int k = 0; k < crm_pkg::OUT_CHANS; k++) chans[k] = '0;
        if (cur_row >= 2 && cur_col >= 2)
        begin
            i = cur_row - 2;
            j = cur_col - 2;
            if (i < 2*POOL_N && j < 2*POOL_N)
            begin
                pc = j / 2;
                for (int f = 0; f < NFILT; f++)
                begin
                    v = filter_relu(f);
                    if (j % 2 == 0) col_left[f] = v;
                    else if (i % 2 == 0) row_max[f][pc] = (col_left[f] > v) ? col_left[f] : v;
                    else
                    begin
                        if (col_left[f] > v) v = col_left[f];
                        if (row_max[f][pc] > v) v = row_max[f][pc];
                        if (f < crm_pkg::OUT_CHANS) chans[f] = v;
                    end
                end
                if (i % 2 == 1 && j % 2 == 1)
                begin
                    res.pool_row  = 4'(i / 2);
                    res.pool_col  = 4'(pc);
                    res.chan0 = chans[0]; res.chan1 = chans[1];
                    res.chan2 = chans[2]; res.chan3 = chans[3];
                    res.chan4 = chans[4]; res.chan5 = chans[5];
                    res.chan6 = chans[6]; res.chan7 = chans[7];
                    res.frame_end = (i / 2 == POOL_N - 1) && (pc == POOL_N - 1);
                    emit = 1;
                end
            end
        end
        cur_col++;
        if (cur_col >= IMG)
        begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= IMG) cur_row = 0;
        end
        return emit;
    endfunction

    // Drive one transaction and wait for its acceptance.
    task automatic send_item(crm_pkg::in_item_t it, bit quiet);
        crm_pkg::out_item_t res;
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        if (pool_step(it, res))
        begin
            if (quiet && it.command == crm_pkg::CMD_COEF)
                $error("coefficient load predicted a pooled result");
            pooled_q.push_back(res);
        end
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every expected result has come.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pooled_q.size() != 0) @(posedge clk);
    endtask

    function automatic crm_pkg::in_item_t random_item();
        crm_pkg::in_item_t it;
        it.command    = ($urandom_range(99) < 88) ? crm_pkg::CMD_PIXEL : crm_pkg::CMD_COEF;
        it.coef_index = crm_pkg::IDX_W'($urandom_range(99) < 90 ? $urandom_range(79)
                                                                : $urandom_range(127));
        case ($urandom_range(5))
            0: it.coef_value = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1: it.coef_value = $urandom();
            default: it.coef_value = 32'($signed(16'($urandom())));
        endcase
        it.pixel = crm_pkg::PIX_W'($urandom());
        return it;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: random stalls plus one long hold-off on request.
    initial
    begin
        dst_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                dst_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge clk);
                hold_req = 0;
            end
            dst_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Compare each pooled transaction with the oldest expectation.
    task automatic check_field(string name, logic [crm_pkg::CHAN_W-1:0] e,
                               logic [crm_pkg::CHAN_W-1:0] a);
        if (e !== a)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, e, a);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        crm_pkg::out_item_t e;
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (pooled_q.size() == 0)
            begin
                $error("unexpected pooled transaction");
                errors++;
            end
            else
            begin
                e = pooled_q.pop_front();
                check_field("pool_row", e.pool_row, dst_data.pool_row);
                check_field("pool_col", e.pool_col, dst_data.pool_col);
                check_field("chan0", e.chan0, dst_data.chan0);
                check_field("chan1", e.chan1, dst_data.chan1);
                check_field("chan2", e.chan2, dst_data.chan2);
                check_field("chan3", e.chan3, dst_data.chan3);
                check_field("chan4", e.chan4, dst_data.chan4);
                check_field("chan5", e.chan5, dst_data.chan5);
                check_field("chan6", e.chan6, dst_data.chan6);
                check_field("chan7", e.chan7, dst_data.chan7);
                check_field("frame_end", e.frame_end, dst_data.frame_end);
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (dst_valid && !dst_stall) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_MAX)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        crm_pkg::in_item_t it;
        hold_req = 0;
        send_idle_pct = 33;
        recv_stall_pct = 68;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        for (int k = 0; k < 2; k++)
            for (int c = 0; c < IMG; c++) line_mem[k][c] = '0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) win[r][c] = '0;
        cur_row = 0;
        cur_col = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load every coefficient before any pixel.
        for (int k = 0; k < NWEIGHTS + NFILT; k++)
        begin
            it = '0;
            it.command = crm_pkg::CMD_COEF;
            it.coef_index = crm_pkg::IDX_W'(k);
            it.coef_value = (k < NWEIGHTS) ? 32'($signed(16'($urandom()))) : $urandom();
            send_item(it, 1);
        end

        // Directed rows.
        foreach (vecs[n])
        begin
            it.command = vecs[n].cmd;
            it.coef_index = crm_pkg::IDX_W'(vecs[n].idx);
            it.coef_value = vecs[n].value;
            it.pixel = vecs[n].pix;
            send_item(it, vecs[n].quiet);
        end

        // Random part in three idling phases.
        for (int n = 0; n < RANDOM_N; n++)
        begin
            if (n == RANDOM_N / 3)
            begin
                send_idle_pct = 68;
                recv_stall_pct = 33;
            end
            if (n == 2 * RANDOM_N / 3)
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
                hold_req = 1;
            end
            if (n == RANDOM_N / 2)
                wait_drained();
            send_item(random_item(), 0);
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- conv3x3_relu_maxpool_layer.f -----
hw/rtl/crm_pkg.sv
hw/rtl/crm_front.sv
hw/rtl/crm_back.sv
hw/rtl/conv3x3_relu_maxpool_layer.sv
hw/rtl/crm_checker.sv
bench/conv3x3_relu_maxpool_layer_tb.sv
